// ===== design/dtf_pkg.sv =====
// Package for the decimal text to fixed-point converter.
// Holds the parse mode codes, character codes, field widths and powers of ten; no dependencies.
`timescale 1ns / 1ps

package dtf_pkg;

  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FRAC = 2'd2;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  localparam int unsigned INT_W   = 31;
  localparam int unsigned FRAC_W  = 32;
  localparam int unsigned INDEX_W = 8;

  localparam logic [INT_W-1:0]   INT_MAX   = '1;
  localparam logic [FRAC_W-1:0]  FRAC_MAX  = '1;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  localparam logic [63:0] POW_TEN [10] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
    64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
  };

endpackage

// ===== design/decimal_text_to_fixed_unit.sv =====
// Top level of the decimal text to fixed-point converter.
// Depends on dtf_pkg for mode codes, character codes, field widths and powers of ten.
//
//   channel  | dir | tdata fields (low bit up)                    | tlast
//   s_axis   | in  | char_code[7:0]                               | line_end
//   m_axis   | out | int_part[30:0], frac_part[31:0],            | last_in_line
//            |     | number_index[7:0], one zero pad bit          |
//
// One character word is taken every cycle unless the word in the input register closes a number
// while the output is stalled; the parse state loads at the edge where a word leaves the input
// register, and the result register loads there too when that word closes a number.
// Reset clears all valid flags and the parse state; no clearing pass is needed.
// A stalled output holds its word; the input register still takes one more word,
// and words that make no result keep flowing while the output is stalled.
`timescale 1ns / 1ps

module decimal_text_to_fixed_unit #(
  parameter int unsigned FRAC_DIGITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // int_part[30:0], frac_part[62:31], number_index[70:63]
  output logic        m_axis_tlast
);

  localparam int unsigned CNT_W   = $clog2(FRAC_DIGITS + 1);
  localparam int unsigned CNT_DEP = 2 ** CNT_W;
  localparam int unsigned INT_W   = dtf_pkg::INT_W;
  localparam int unsigned FRAC_W  = dtf_pkg::FRAC_W;
  localparam int unsigned INDEX_W = dtf_pkg::INDEX_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FRAC_DIGITS);

  // Rounded fraction terms round(d * 2^32 / 10^(k+1)), built at elaboration.
  logic [FRAC_W-1:0] term_tab [CNT_DEP][16];

  for (genvar k = 0; k < CNT_DEP; k++) begin : g_pos
    for (genvar d = 0; d < 16; d++) begin : g_dig
      if (k < FRAC_DIGITS && d < 10) begin : g_term
        localparam logic [63:0] P = dtf_pkg::POW_TEN[k + 1];
        localparam logic [63:0] T = ((64'(d) << 32) + (P >> 1)) / P;
        assign term_tab[k][d] = T[FRAC_W-1:0];
      end else begin : g_zero
        assign term_tab[k][d] = '0;
      end
    end
  end

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Parse state.
  logic [dtf_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [INT_W-1:0]           int_q, int_d;
  logic [FRAC_W-1:0]          frac_q, frac_d;
  logic [CNT_W-1:0]           fcnt_q, fcnt_d;
  logic [INDEX_W-1:0]         ncnt_q, ncnt_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [INT_W-1:0]   out_int_q;
  logic [FRAC_W-1:0]  out_frac_q;
  logic [INDEX_W-1:0] out_index_q;
  logic               out_last_q;

  logic              is_digit, is_dot, emit, out_free, proc;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_next;
  logic [FRAC_W:0]   frac_sum;
  logic [INT_W-1:0]  join_int;
  logic [FRAC_W-1:0] join_frac;

  always_comb begin
    is_digit = (in_char_q >= dtf_pkg::CHAR_ZERO) && (in_char_q <= dtf_pkg::CHAR_NINE);
    is_dot   = (in_char_q == dtf_pkg::CHAR_DOT);
    digit    = 4'(in_char_q - dtf_pkg::CHAR_ZERO);
    int_next = ({1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0}) + (INT_W+4)'(digit);
    frac_sum = {1'b0, frac_q} + {1'b0, term_tab[fcnt_q][digit]};
    if (is_digit || is_dot) begin
      emit = in_last_q;
    end else begin
      emit = (mode_q != dtf_pkg::MODE_IDLE);
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || proc;

  always_comb begin
    in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
    out_valid_d = (proc && emit) ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    mode_d = mode_q;
    int_d  = int_q;
    frac_d = frac_q;
    fcnt_d = fcnt_q;
    ncnt_d = ncnt_q;
    if (is_digit) begin
      if (mode_q == dtf_pkg::MODE_FRAC) begin
        if (fcnt_q < CNT_LIMIT) begin
          frac_d = frac_sum[FRAC_W] ? dtf_pkg::FRAC_MAX : frac_sum[FRAC_W-1:0];
          fcnt_d = fcnt_q + CNT_W'(1);
        end
      end else begin
        int_d  = (int_next > (INT_W+4)'(dtf_pkg::INT_MAX)) ? dtf_pkg::INT_MAX
                                                           : int_next[INT_W-1:0];
        mode_d = dtf_pkg::MODE_INT;
      end
    end else if (is_dot) begin
      mode_d = dtf_pkg::MODE_FRAC;
    end
    // The number as it stands once this character has joined it.
    join_int  = int_d;
    join_frac = frac_d;
    if (emit) begin
      mode_d = dtf_pkg::MODE_IDLE;
      int_d  = '0;
      frac_d = '0;
      fcnt_d = '0;
      if (ncnt_q != dtf_pkg::INDEX_MAX) begin
        ncnt_d = ncnt_q + INDEX_W'(1);
      end
    end
    if (in_last_q) begin
      mode_d = dtf_pkg::MODE_IDLE;
      int_d  = '0;
      frac_d = '0;
      fcnt_d = '0;
      ncnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= dtf_pkg::MODE_IDLE;
      int_q       <= '0;
      frac_q      <= '0;
      fcnt_q      <= '0;
      ncnt_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (proc) begin
        mode_q <= mode_d;
        int_q  <= int_d;
        frac_q <= frac_d;
        fcnt_q <= fcnt_d;
        ncnt_q <= ncnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (proc && emit) begin
      // A separator leaves the number unchanged; a digit or dot at the line end
      // joins it before it is emitted.
      out_int_q   <= join_int;
      out_frac_q  <= join_frac;
      out_index_q <= ncnt_q;
      out_last_q  <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_index_q, out_frac_q, out_int_q};
  assign m_axis_tlast  = out_last_q;

  // A word in the input register is never overwritten before it is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (!in_valid_q || proc))
    else $error("input register overwritten");

  // An idle parser holds an empty number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == dtf_pkg::MODE_IDLE) |-> (int_q == '0 && frac_q == '0 && fcnt_q == '0))
    else $error("idle parser holds a number");

  // The fraction digit count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CNT_LIMIT)
    else $error("fraction digit count out of range");

  // A line end clears the whole parse state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |=> (ncnt_q == '0 && mode_q == dtf_pkg::MODE_IDLE))
    else $error("line end did not clear state");

  // A result word is never replaced while it waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(proc && emit))
    else $error("pending result overwritten");

endmodule

// ===== tb/fixed_number_checker.sv =====
// Checker for the decimal text to fixed-point converter: it watches both stream channels,
// predicts every parsed number from the accepted character words and compares them.
// Depends on dtf_pkg for mode codes, character codes, field widths and powers of ten.
`timescale 1ns / 1ps

module fixed_number_checker
  import dtf_pkg::*;
#(
  parameter int unsigned FRAC_DIGITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [71:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [INT_W-1:0]   int_part;
    logic [FRAC_W-1:0]  frac_part;
    logic [INDEX_W-1:0] number_index;
    logic               last_in_line;
  } parsed_number_t;

  parsed_number_t     expected_numbers[$];
  logic [MODE_W-1:0]  mode;
  logic [INT_W-1:0]   int_acc;
  logic [FRAC_W-1:0]  frac_acc;
  int unsigned        frac_taken;
  logic [INDEX_W-1:0] numbers_in_line;
  int unsigned        mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic clear_number();
    mode       = MODE_IDLE;
    int_acc    = '0;
    frac_acc   = '0;
    frac_taken = 0;
  endtask

  // Advances the parse state by one character word and queues the number it closes, if any.
  task automatic parse_char(input logic [7:0] ch, input logic eol);
    logic [3:0]     digit;
    logic [63:0]    wide;
    logic [63:0]    term;
    logic           emit;
    parsed_number_t num;
    emit = 1'b0;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      digit = 4'(ch - CHAR_ZERO);
      if (mode == MODE_FRAC) begin
        // Digits past the configured fraction depth are dropped.
        if (frac_taken < FRAC_DIGITS && frac_taken < 9) begin
          term = (({60'd0, digit} << 32) + (POW_TEN[frac_taken + 1] >> 1))
                 / POW_TEN[frac_taken + 1];
          wide = {32'd0, frac_acc} + term;
          frac_acc = (wide > {32'd0, FRAC_MAX}) ? FRAC_MAX : wide[FRAC_W-1:0];
          frac_taken++;
        end
      end else begin
        wide = {33'd0, int_acc} * 64'd10 + {60'd0, digit};
        int_acc = (wide > {33'd0, INT_MAX}) ? INT_MAX : wide[INT_W-1:0];
        mode = MODE_INT;
      end
      emit = eol;
    end else if (ch == CHAR_DOT) begin
      mode = MODE_FRAC;
      emit = eol;
    end else begin
      emit = (mode != MODE_IDLE);
    end
    if (emit) begin
      num.int_part     = int_acc;
      num.frac_part    = frac_acc;
      num.number_index = numbers_in_line;
      num.last_in_line = eol;
      expected_numbers = {expected_numbers, num};
      if (numbers_in_line != INDEX_MAX) numbers_in_line++;
      clear_number();
    end
    if (eol) begin
      clear_number();
      numbers_in_line = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    parsed_number_t want;
    if (!rst_ni) begin
      clear_number();
      numbers_in_line = '0;
      expected_numbers.delete();
      mismatch_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) parse_char(s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_numbers.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected: tdata=%h tlast=%b",
                                    m_tdata_i, m_tlast_i));
        end else begin
          want = expected_numbers.pop_front();
          if (m_tdata_i[30:0] !== want.int_part)
            report_mismatch($sformatf("int_part expected %0d got %0d",
                                      want.int_part, m_tdata_i[30:0]));
          if (m_tdata_i[62:31] !== want.frac_part)
            report_mismatch($sformatf("frac_part expected %h got %h",
                                      want.frac_part, m_tdata_i[62:31]));
          if (m_tdata_i[70:63] !== want.number_index)
            report_mismatch($sformatf("number_index expected %0d got %0d",
                                      want.number_index, m_tdata_i[70:63]));
          if (m_tlast_i !== want.last_in_line)
            report_mismatch($sformatf("last_in_line expected %b got %b",
                                      want.last_in_line, m_tlast_i));
          if (m_tdata_i[71] !== 1'b0)
            report_mismatch($sformatf("pad bit expected 0 got %b", m_tdata_i[71]));
        end
      end
      mismatches_o <= mismatch_count;
      pending_o    <= expected_numbers.size();
    end
  end

endmodule

// ===== tb/decimal_text_to_fixed_unit_tb.sv =====
// Testbench top for decimal_text_to_fixed_unit: drives character lines in bursts, stalls
// the result side, and takes the verdict from fixed_number_checker.
// Depends on dtf_pkg and on fixed_number_checker.
`timescale 1ns / 1ps

module decimal_text_to_fixed_unit_tb;
  import dtf_pkg::*;

  localparam int unsigned FRAC_DIGITS     = 6;
  localparam int unsigned RANDOM_WORDS    = 1150;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned LIMIT_CYCLES    = 400000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count  = 0;
  int unsigned words_sent   = 0;
  int unsigned burst_left   = 4;
  logic        valid_up     = 1'b0;
  logic        hold_off_req = 1'b0;
  logic [7:0]  line_q[$];

  always #6 clk_i = ~clk_i;

  decimal_text_to_fixed_unit #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  fixed_number_checker #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one character word and returns once it is taken; valid stays up inside a burst.
  task automatic send_word(input logic [7:0] ch, input logic eol);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eol;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_text(input string text, input logic eol);
    for (int i = 0; i < text.len(); i++) send_word(text[i], eol && (i == text.len() - 1));
  endtask

  task automatic send_line_q();
    for (int i = 0; i < line_q.size(); i++) send_word(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Adds one character to the end of the line being built.
  task automatic append_char(input logic [7:0] ch);
    line_q = {line_q, ch};
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == CHAR_DOT);
    return ch;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CHAR_ZERO + $urandom_range(0, 9));
  endfunction

  // Appends one number token: optional integer digits, optional dot and fraction digits,
  // now and then a stray dot inside the fraction. Long integer runs reach saturation.
  task automatic push_number();
    int unsigned n_int;
    int unsigned n_frac;
    logic        has_dot;
    n_int   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 5);
    has_dot = ($urandom_range(0, 2) != 0);
    n_frac  = has_dot ? $urandom_range(0, 8) : 0;
    if (n_int == 0 && !has_dot) n_int = 1;
    repeat (n_int) append_char(pick_digit());
    if (has_dot) begin
      append_char(CHAR_DOT);
      repeat (n_frac) begin
        append_char(pick_digit());
        if ($urandom_range(0, 15) == 0) append_char(CHAR_DOT);
      end
    end
  endtask

  // Result side: random stall patterns, and one long hold-off on request so the block backs up.
  initial begin
    int unsigned stall_kind;
    int unsigned run_len;
    logic        hold_off_done;
    hold_off_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        stall_kind = $urandom_range(0, 3);
        run_len    = $urandom_range(1, 40);
        repeat (run_len) begin
          case (stall_kind)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    logic long_line_done;
    int   n_numbers;
    long_line_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines: single digit at line end, lone dot, separators while idle,
    // integer saturation closed by a separator, and a fraction with a surplus digit
    // closed by a separator at line end.
    send_text("0", 1'b1);
    send_text(".", 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    send_text("9999999999,", 1'b0);
    send_text(".9999999-", 1'b1);

    hold_off_req <= 1'b1;
    while (words_sent < RANDOM_WORDS) begin
      if (!long_line_done && words_sent > 400) begin
        // Enough numbers in one line to saturate the number index.
        repeat (260) begin
          append_char(pick_digit());
          append_char(pick_separator());
        end
        long_line_done = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) append_char(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 4) == 0) append_char(pick_separator());
        n_numbers = $urandom_range(1, 5);
        for (int i = 0; i < n_numbers; i++) begin
          push_number();
          if (i < n_numbers - 1 || $urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 2)) append_char(pick_separator());
          end
        end
      end
      send_line_q();
    end
    if (valid_up) s_axis_tvalid <= 1'b0;

    // The checker's count includes the last word only after the next edge.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
